>>> sv/hcd_pkg.sv
// Package for the chunked body decoder: payload structs, result kind codes,
// decoder phase codes and the hex digit decode. No dependencies.
package hcd_pkg;

  localparam int unsigned SizeWidthDef  = 32;
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned OutCountWidth = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]               out_byte;
    logic [1:0]               out_kind;
    logic [OutCountWidth-1:0] payload_count;
  } out_t;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END_OK  = 2'd1;
  localparam logic [1:0] KIND_END_ERR = 2'd2;

  // decoder phases
  localparam logic [2:0] PH_SIZE_FIRST = 3'd0;
  localparam logic [2:0] PH_SIZE_MORE  = 3'd1;
  localparam logic [2:0] PH_SKIP_LINE  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD    = 3'd3;
  localparam logic [2:0] PH_SEP_FIRST  = 3'd4;
  localparam logic [2:0] PH_SEP_LF     = 3'd5;
  localparam logic [2:0] PH_DONE       = 3'd6;
  localparam logic [2:0] PH_ERROR      = 3'd7;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [4:0] NotHex    = 5'd16;

  // hex digit value, or NotHex
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      v = c - CharZero;
    end else if (c >= CharLowA && c <= CharLowF) begin
      v = c - CharLowA + 8'd10;
    end else if (c >= CharUpA && c <= CharUpF) begin
      v = c - CharUpA + 8'd10;
    end else begin
      v = {3'b000, NotHex};
    end
    return v[4:0];
  endfunction

endpackage

>>> sv/http_chunked_decoder.sv
// Top level of the chunked HTTP body decoder; depends on hcd_pkg and hcd_step.
// Path: a byte taken at the input is held in the input register, and its result is
// written to the output register when that byte is consumed and the output is free.
// Throughput: one byte per cycle while the output side is free; a byte with a result waits on out_ready_i.
// Reset: rst_ni asynchronous, clears both stage valids and the decoder state.
module http_chunked_decoder import hcd_pkg::*; #(
  parameter int unsigned SIZE_WIDTH  = SizeWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output out_t out_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  logic                   in_valid_q;
  in_t                    in_q;
  logic [2:0]             phase_q, phase_d;
  logic [SIZE_WIDTH-1:0]  chunk_q, chunk_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic                   out_valid_q;
  out_t                   out_q;

  logic res_valid;
  out_t res;
  logic out_free;
  logic advance;

  hcd_step #(
    .SIZE_WIDTH (SIZE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .item_i     (in_q),
    .phase_i    (phase_q),
    .chunk_i    (chunk_q),
    .total_i    (total_q),
    .phase_o    (phase_d),
    .chunk_o    (chunk_d),
    .total_o    (total_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // a byte with no result never waits on the output side
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE_FIRST;
      chunk_q <= '0;
      total_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      chunk_q <= chunk_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.out_kind == KIND_PAYLOAD || out_q.out_kind == KIND_END_OK ||
                     out_q.out_kind == KIND_END_ERR))
    else $error("illegal result kind");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_kind != KIND_PAYLOAD) |-> (out_q.out_byte == 8'd0))
    else $error("end result carries a data byte");

  a_payload_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_kind == KIND_PAYLOAD) |-> (out_q.payload_count != '0))
    else $error("payload result with zero count");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.last_byte) |=> (phase_q == PH_SIZE_FIRST && total_q == '0))
    else $error("decoder state not cleared after end of body");

endmodule

>>> sv/hcd_step.sv
// Next-state and result logic of the chunked body decoder for one byte.
// Purely combinational; depends on hcd_pkg.
module hcd_step import hcd_pkg::*; #(
  parameter int unsigned SIZE_WIDTH  = SizeWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  in_t                    item_i,
  input  logic [2:0]             phase_i,
  input  logic [SIZE_WIDTH-1:0]  chunk_i,
  input  logic [COUNT_WIDTH-1:0] total_i,
  output logic [2:0]             phase_o,
  output logic [SIZE_WIDTH-1:0]  chunk_o,
  output logic [COUNT_WIDTH-1:0] total_o,
  output logic                   res_valid_o,
  output out_t                   res_o
);

  logic [4:0] hex;
  logic       is_hex;
  logic       is_lf;
  logic [2:0] line_done_phase;

  assign hex             = hex_value(item_i.data_byte);
  assign is_hex          = (hex != NotHex);
  assign is_lf           = (item_i.data_byte == CharLf);
  assign line_done_phase = (chunk_i == '0) ? PH_DONE : PH_PAYLOAD;

  always_comb begin
    phase_o     = phase_i;
    chunk_o     = chunk_i;
    total_o     = total_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_i)
      PH_SIZE_FIRST: begin
        if (!is_hex) begin
          phase_o = PH_ERROR;
        end else begin
          chunk_o = SIZE_WIDTH'(hex[3:0]);
          phase_o = PH_SIZE_MORE;
        end
      end
      PH_SIZE_MORE: begin
        if (is_hex) begin
          // another digit would push bits past the size width
          if (chunk_i[SIZE_WIDTH-1 -: 4] != 4'd0) begin
            phase_o = PH_ERROR;
          end else begin
            chunk_o = {chunk_i[SIZE_WIDTH-5:0], hex[3:0]};
          end
        end else if (is_lf) begin
          phase_o = line_done_phase;
        end else begin
          phase_o = PH_SKIP_LINE;
        end
      end
      PH_SKIP_LINE: begin
        if (is_lf) begin
          phase_o = line_done_phase;
        end
      end
      PH_PAYLOAD: begin
        if (item_i.last_byte || (&total_i)) begin
          phase_o = PH_ERROR;
        end else begin
          total_o = total_i + 1'b1;
          chunk_o = chunk_i - 1'b1;
          if (chunk_i == SIZE_WIDTH'(1)) begin
            phase_o = PH_SEP_FIRST;
          end
          res_valid_o         = 1'b1;
          res_o.out_byte      = item_i.data_byte;
          res_o.out_kind      = KIND_PAYLOAD;
          res_o.payload_count = OutCountWidth'(total_o);
        end
      end
      PH_SEP_FIRST: begin
        if (item_i.data_byte == CharCr) begin
          phase_o = PH_SEP_LF;
        end else if (is_lf) begin
          phase_o = PH_SIZE_FIRST;
        end else begin
          phase_o = PH_ERROR;
        end
      end
      PH_SEP_LF: begin
        phase_o = is_lf ? PH_SIZE_FIRST : PH_ERROR;
      end
      default: begin
      end
    endcase

    // end of body: report and start over
    if (item_i.last_byte) begin
      res_valid_o         = 1'b1;
      res_o.out_byte      = 8'd0;
      res_o.out_kind      = (phase_o == PH_DONE) ? KIND_END_OK : KIND_END_ERR;
      res_o.payload_count = OutCountWidth'(total_o);
      phase_o             = PH_SIZE_FIRST;
      chunk_o             = '0;
      total_o             = '0;
    end
  end

endmodule

>>> tb/http_chunked_decoder_tb.sv
// Self-checking bench for the chunked HTTP body decoder: directed table then random
// bodies, checked against a cycle-free decoder predictor. Depends on hcd_pkg.
module http_chunked_decoder_tb;
  import hcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200_000;
  localparam int RandomItems = 400;
  localparam int DrainCycles = 8;
  localparam int MaxPrinted  = 40;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        pinned;
    logic [1:0]  kind;
    logic [31:0] count;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  in_t  in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;

  // decoder predictor state
  logic [2:0]               dec_phase = PH_SIZE_FIRST;
  logic [SizeWidthDef-1:0]  chunk_left = '0;
  logic [CountWidthDef-1:0] byte_total = '0;

  out_t expected_results[$];
  in_t  body_bytes[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   live_items = 0;
  int   bodies_sent = 0;
  int   payload_seen = 0;
  int   ok_seen = 0;
  int   err_seen = 0;
  bit   calm = 1'b0;

  // directed rows: bad first digit, skipped extension with trailing bytes after the end,
  // CR followed by junk, last byte inside a payload, size that outgrows the size width
  dir_row_t directed_rows [26] = '{
    '{8'hff,   1'b1, 1'b1, KIND_END_ERR, 32'd0},
    '{"1",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{";",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{CharLf,  1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{8'hff,   1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{CharLf,  1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{CharLf,  1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"Z",     1'b1, 1'b1, KIND_END_OK,  32'd1},
    '{"1",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{CharLf,  1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{8'h00,   1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{CharCr,  1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"x",     1'b1, 1'b1, KIND_END_ERR, 32'd1},
    '{"f",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{CharLf,  1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"a",     1'b1, 1'b1, KIND_END_ERR, 32'd0},
    '{"A",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b0, 1'b0, KIND_PAYLOAD, 32'd0},
    '{"0",     1'b1, 1'b1, KIND_END_ERR, 32'd0}
  };

  http_chunked_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_o       (out_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  always #10 clk_i = ~clk_i;

  // low nibble of the ascii code gives the digit, letters need +9
  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      v = c[3:0] + 4'd9;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit decode_step(input in_t item, output out_t res);
    logic [3:0] nib;
    bit         is_digit;
    bit         emitted;
    emitted  = 1'b0;
    res      = '0;
    is_digit = hex_digit(item.data_byte, nib);
    case (dec_phase)
      PH_SIZE_FIRST: begin
        if (!is_digit) begin
          dec_phase = PH_ERROR;
        end else begin
          chunk_left = SizeWidthDef'(nib);
          dec_phase  = PH_SIZE_MORE;
        end
      end
      PH_SIZE_MORE: begin
        if (is_digit) begin
          if (chunk_left[SizeWidthDef-1 -: 4] != 4'd0) begin
            dec_phase = PH_ERROR;
          end else begin
            chunk_left = {chunk_left[SizeWidthDef-5:0], nib};
          end
        end else if (item.data_byte == CharLf) begin
          dec_phase = (chunk_left == '0) ? PH_DONE : PH_PAYLOAD;
        end else begin
          dec_phase = PH_SKIP_LINE;
        end
      end
      PH_SKIP_LINE: begin
        if (item.data_byte == CharLf) begin
          dec_phase = (chunk_left == '0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // a last byte or a full counter drops the byte and latches the error
        if (item.last_byte || byte_total == '1) begin
          dec_phase = PH_ERROR;
        end else begin
          byte_total = byte_total + 1'b1;
          chunk_left = chunk_left - 1'b1;
          if (chunk_left == '0) begin
            dec_phase = PH_SEP_FIRST;
          end
          res.out_byte      = item.data_byte;
          res.out_kind      = KIND_PAYLOAD;
          res.payload_count = byte_total[OutCountWidth-1:0];
          emitted           = 1'b1;
        end
      end
      PH_SEP_FIRST: begin
        if (item.data_byte == CharCr) begin
          dec_phase = PH_SEP_LF;
        end else if (item.data_byte == CharLf) begin
          dec_phase = PH_SIZE_FIRST;
        end else begin
          dec_phase = PH_ERROR;
        end
      end
      PH_SEP_LF: begin
        dec_phase = (item.data_byte == CharLf) ? PH_SIZE_FIRST : PH_ERROR;
      end
      default: begin
      end
    endcase
    if (item.last_byte) begin
      res.out_byte      = 8'd0;
      res.out_kind      = (dec_phase == PH_DONE) ? KIND_END_OK : KIND_END_ERR;
      res.payload_count = byte_total[OutCountWidth-1:0];
      emitted           = 1'b1;
      dec_phase         = PH_SIZE_FIRST;
      chunk_left        = '0;
      byte_total        = '0;
    end
    return emitted;
  endfunction

  // mostly no gap, some short, a few long; none at all during calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MaxPrinted) begin
      $display("%0t ns: %s got %0h, want %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // one transfer on the input side, then the predicted result goes in the queue
  task automatic send_item(input in_t item, input bit pinned, input out_t pin_val);
    int   gap;
    out_t res;
    bit   emitted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if ((dec_phase != PH_DONE && dec_phase != PH_ERROR) || item.last_byte) begin
      live_items++;
    end
    emitted = decode_step(item, res);
    if (pinned) begin
      expected_results.push_back(pin_val);
    end else if (emitted) begin
      expected_results.push_back(res);
    end
  endtask

  function automatic void add_byte(input logic [7:0] b);
    body_bytes.push_back('{data_byte: b, last_byte: 1'b0});
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CharZero + 8'(n);
    end
    return (($urandom_range(0, 1) != 0) ? CharUpA : CharLowA) + 8'(n) - 8'd10;
  endfunction

  // size line: optional leading zeros, digits in mixed case, optional extension
  function automatic void add_size_line(input logic [35:0] value);
    int         top;
    logic [7:0] b;
    top = 8;
    while (top > 0 && value[top*4 +: 4] == 4'd0) top--;
    repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0) add_byte(CharZero);
    for (int i = top; i >= 0; i--) add_byte(digit_char(value[i*4 +: 4]));
    if ($urandom_range(0, 3) == 0) begin
      add_byte(";");
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom);
        add_byte((b == CharLf) ? 8'h20 : b);
      end
    end
    if ($urandom_range(0, 1) != 0) begin
      add_byte(CharCr);
    end
    add_byte(CharLf);
  endfunction

  function automatic void build_body();
    int style;
    int size;
    int keep;
    body_bytes = {};
    style = $urandom_range(0, 9);
    if (style == 9) begin
      case ($urandom_range(0, 2))
        0: repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
        1: add_size_line({4'($urandom_range(1, 15)), 32'($urandom)});
        default: begin
          add_size_line(36'hffffffff);
          repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
        end
      endcase
      if (body_bytes.size() == 0) begin
        add_byte(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(0, 3)) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 8);
        add_size_line(36'(size));
        repeat (size) add_byte(8'($urandom));
        if ($urandom_range(0, 1) != 0) begin
          add_byte(CharCr);
        end
        add_byte(CharLf);
      end
      add_size_line(36'd0);
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) add_byte(8'($urandom));
      if (style == 7) begin
        keep = $urandom_range(1, body_bytes.size());
        while (body_bytes.size() > keep) void'(body_bytes.pop_back());
      end else if (style == 8) begin
        body_bytes[$urandom_range(0, body_bytes.size() - 1)].data_byte = 8'($urandom);
      end
    end
    body_bytes[body_bytes.size() - 1].last_byte = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: compare every transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", 32'(out_data.out_kind), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.out_kind != want.out_kind) begin
          report_mismatch("out_kind", 32'(out_data.out_kind), 32'(want.out_kind));
        end
        if (out_data.out_byte != want.out_byte) begin
          report_mismatch("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
        end
        if (out_data.payload_count != want.payload_count) begin
          report_mismatch("payload_count", out_data.payload_count, want.payload_count);
        end
      end
      case (out_data.out_kind)
        KIND_PAYLOAD: payload_seen++;
        KIND_END_OK:  ok_seen++;
        default:      err_seen++;
      endcase
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    in_t  item;
    out_t pin_val;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      item    = '{data_byte: directed_rows[i].data, last_byte: directed_rows[i].last};
      pin_val = '{out_byte: 8'd0, out_kind: directed_rows[i].kind,
                  payload_count: directed_rows[i].count};
      send_item(item, directed_rows[i].pinned, pin_val);
    end

    live_items = 0;
    while (live_items < RandomItems) begin
      build_body();
      foreach (body_bytes[i]) send_item(body_bytes[i], 1'b0, '0);
      bodies_sent++;
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d directed bytes and %0d random bodies (%0d live bytes)",
             $size(directed_rows), bodies_sent, live_items);
    $display("seen %0d payload bytes, %0d clean ends, %0d error ends, %0d mismatches",
             payload_seen, ok_seen, err_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
